// File: sv/ps2mt_pkg.sv
// Shared types, codes and a clamp helper function for the PS/2 mouse packet tracker.
package ps2mt_pkg;

    localparam int COORD_BITS = 16;
    localparam int WIDE_BITS  = COORD_BITS + 2;

    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam int HDR_XOVF_BIT  = 6;
    localparam int HDR_YOVF_BIT  = 7;

    localparam int EV_DOWN = 0;
    localparam int EV_UP   = 1;
    localparam int EV_MOVE = 2;

    localparam logic signed [COORD_BITS-1:0] RST_CURSOR_X = 16'sd511;
    localparam logic signed [COORD_BITS-1:0] RST_CURSOR_Y = 16'sd383;
    localparam logic signed [COORD_BITS-1:0] RST_MAX_X    = 16'sd1023;
    localparam logic signed [COORD_BITS-1:0] RST_MAX_Y    = 16'sd767;

    typedef enum logic [1:0] {
        FUNC_BYTE   = 2'd0,
        FUNC_SETPOS = 2'd1,
        FUNC_FLUSH  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_MOVE = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_UP   = 2'd2,
        KIND_DRAG = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_MIN_X = 2'd0,
        REG_MIN_Y = 2'd1,
        REG_MAX_X = 2'd2,
        REG_MAX_Y = 2'd3
    } t_reg;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
    } t_bounds;

    typedef struct packed {
        logic signed [8:0]            dx;
        logic signed [9:0]            dy;
        logic [2:0]                   btn;
        logic [2:0]                   mask;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
    } t_pkt;

    function automatic logic signed [COORD_BITS-1:0] clamp(
        input logic signed [WIDE_BITS-1:0]  v,
        input logic signed [COORD_BITS-1:0] lo,
        input logic signed [COORD_BITS-1:0] hi
    );
        logic signed [WIDE_BITS-1:0] r;
        logic signed [WIDE_BITS-1:0] lo_w;
        logic signed [WIDE_BITS-1:0] hi_w;
        lo_w = WIDE_BITS'(lo);
        hi_w = WIDE_BITS'(hi);
        r = v;
        if (r < lo_w) begin
            r = lo_w;
        end
        if (r > hi_w) begin
            r = hi_w;
        end
        return r[COORD_BITS-1:0];
    endfunction

endpackage

// File: sv/ps2mt_front.sv
// Front end: accepts beats, assembles packets, tracks the cursor and queues event records.
module ps2mt_front
    import ps2mt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_func,
    input  logic [7:0]            i_rx_byte,
    input  logic signed [15:0]    i_new_x,
    input  logic signed [15:0]    i_new_y,
    input  t_bounds               i_bounds,
    input  logic                  i_full,
    output logic                  o_push,
    output t_pkt                  o_pkt
);

    logic [1:0]                   r_count, n_count;
    logic [7:0]                   r_status, n_status;
    logic [7:0]                   r_xbyte, n_xbyte;
    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [2:0]                   r_prev, n_prev;

    logic                         w_acc;
    t_func                        w_func;
    logic signed [8:0]            w_dx;
    logic signed [9:0]            w_dy;
    logic [2:0]                   w_btn;
    logic [2:0]                   w_pressed;
    logic [2:0]                   w_released;
    logic signed [COORD_BITS-1:0] w_pkt_x;
    logic signed [COORD_BITS-1:0] w_pkt_y;
    logic                         w_third;
    logic                         w_ovf;

    assign o_ready = i_rst_n && !i_full;
    assign w_acc   = i_valid && o_ready;
    assign w_func  = t_func'(i_func);

    assign w_dx  = {r_status[HDR_XSIGN_BIT], r_xbyte};
    assign w_dy  = -{{1{r_status[HDR_YSIGN_BIT]}}, r_status[HDR_YSIGN_BIT], i_rx_byte};
    assign w_btn = r_status[2:0];
    assign w_pressed  = (w_btn ^ r_prev) & w_btn;
    assign w_released = (w_btn ^ r_prev) & r_prev;
    assign w_ovf   = r_status[HDR_XOVF_BIT] || r_status[HDR_YOVF_BIT];
    assign w_third = w_acc && (w_func == FUNC_BYTE) && (r_count == 2'd2);

    assign w_pkt_x = clamp(WIDE_BITS'(r_cur_x) + WIDE_BITS'(w_dx), i_bounds.min_x,
                           i_bounds.max_x);
    assign w_pkt_y = clamp(WIDE_BITS'(r_cur_y) + WIDE_BITS'(w_dy), i_bounds.min_y,
                           i_bounds.max_y);

    always_comb begin
        o_pkt.dx    = w_dx;
        o_pkt.dy    = w_dy;
        o_pkt.btn   = w_btn;
        o_pkt.mask  = {(w_dx != 9'sd0) || (w_dy != 10'sd0), |w_released, |w_pressed};
        o_pkt.pos_x = w_pkt_x;
        o_pkt.pos_y = w_pkt_y;
        o_push      = w_third && !w_ovf && (o_pkt.mask != 3'b000);
    end

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        n_xbyte  = r_xbyte;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_prev   = r_prev;
        if (w_acc) begin
            unique case (w_func)
                FUNC_SETPOS: begin
                    n_cur_x = clamp(WIDE_BITS'(i_new_x), i_bounds.min_x, i_bounds.max_x);
                    n_cur_y = clamp(WIDE_BITS'(i_new_y), i_bounds.min_y, i_bounds.max_y);
                end
                FUNC_FLUSH: begin
                    n_count = 2'd0;
                end
                FUNC_BYTE: begin
                    priority if (r_count == 2'd0) begin
                        if (i_rx_byte[HDR_SYNC_BIT]) begin
                            n_status = i_rx_byte;
                            n_count  = 2'd1;
                        end
                    end else if (r_count == 2'd1) begin
                        n_xbyte = i_rx_byte;
                        n_count = 2'd2;
                    end else begin
                        n_count = 2'd0;
                        if (!w_ovf) begin
                            n_cur_x = w_pkt_x;
                            n_cur_y = w_pkt_y;
                            n_prev  = w_btn;
                        end
                    end
                end
                FUNC_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_status <= 8'd0;
            r_xbyte  <= 8'd0;
            r_cur_x  <= RST_CURSOR_X;
            r_cur_y  <= RST_CURSOR_Y;
            r_prev   <= 3'd0;
        end else begin
            r_count  <= n_count;
            r_status <= n_status;
            r_xbyte  <= n_xbyte;
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_prev   <= n_prev;
        end
    end

endmodule

// File: sv/ps2mt_queue.sv
// Small queue of packet records between the front end and the back end.
module ps2mt_queue
    import ps2mt_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    input  logic i_pop,
    output t_pkt o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: sv/ps2mt_back.sv
// Back end: expands each packet record into its event beats, one per cycle while the output is ready.
module ps2mt_back
    import ps2mt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pkt        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [55:0] o_data,
    output logic        o_last
);

    logic [2:0]  r_done, n_done;
    logic        r_valid, n_valid;
    logic [55:0] r_data;
    logic        r_last;

    logic [2:0]  w_rem;
    logic [2:0]  w_sel;
    logic        w_fin;
    logic        w_load;
    t_kind       w_kind;

    assign w_rem  = i_head.mask & ~r_done;
    assign w_load = !i_empty && (!r_valid || i_ready);

    always_comb begin
        w_sel  = 3'b000;
        w_kind = KIND_MOVE;
        priority if (w_rem[EV_DOWN]) begin
            w_sel[EV_DOWN] = 1'b1;
            w_kind         = KIND_DOWN;
        end else if (w_rem[EV_UP]) begin
            w_sel[EV_UP] = 1'b1;
            w_kind       = KIND_UP;
        end else begin
            w_sel[EV_MOVE] = 1'b1;
            w_kind         = (i_head.btn != 3'b000) ? KIND_DRAG : KIND_MOVE;
        end
        w_fin = ((w_rem & ~w_sel) == 3'b000);
    end

    assign o_pop = w_load && w_fin;

    always_comb begin
        n_done  = r_done;
        n_valid = r_valid;
        if (w_load) begin
            n_done  = w_fin ? 3'b000 : (r_done | w_sel);
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= {i_head.pos_y, i_head.pos_x, i_head.btn, i_head.dy, i_head.dx, w_kind};
            r_last <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 3'b000;
            r_valid <= 1'b0;
        end else begin
            r_done  <= n_done;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

// File: sv/ps2_mouse_packet_tracker_top.sv
// Top level of the PS/2 mouse packet tracker with its register port.
//
// The block takes one input beat per cycle as long as its packet queue has room; a beat
// that completes a three-byte packet without overflow and with at least one event is turned
// into a record in the front end and queued, and the back end sends that record's events
// (button down, button up, move or drag) one beat per cycle while the output is ready,
// through an output register, and QUEUE_DEPTH records may wait while the output is stalled.
// Set-position, flush, dropped and discarded beats produce no output.
module ps2_mouse_packet_tracker_top
    import ps2mt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // rx_byte, new_x, new_y
    input  logic [1:0]  i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // event_kind, delta_x, delta_y, button_bits, pos_x, pos_y
    output logic        o_m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_bounds r_bounds;
    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_empty;
    t_pkt    w_pkt;
    t_pkt    w_head;
    t_reg    w_reg;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.min_x <= '0;
            r_bounds.min_y <= '0;
            r_bounds.max_x <= RST_MAX_X;
            r_bounds.max_y <= RST_MAX_Y;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg)
                REG_MIN_X: r_bounds.min_x <= pwdata[15:0];
                REG_MIN_Y: r_bounds.min_y <= pwdata[15:0];
                REG_MAX_X: r_bounds.max_x <= pwdata[15:0];
                REG_MAX_Y: r_bounds.max_y <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_MIN_X: prdata = {16'd0, r_bounds.min_x};
            REG_MIN_Y: prdata = {16'd0, r_bounds.min_y};
            REG_MAX_X: prdata = {16'd0, r_bounds.max_x};
            REG_MAX_Y: prdata = {16'd0, r_bounds.max_y};
            default:   prdata = 32'd0;
        endcase
    end

    ps2mt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_func    (i_s_tuser),
        .i_rx_byte (i_s_tdata[7:0]),
        .i_new_x   (i_s_tdata[23:8]),
        .i_new_y   (i_s_tdata[39:24]),
        .i_bounds  (r_bounds),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_pkt     (w_pkt)
    );

    ps2mt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_pkt),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ps2mt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("Packet record pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("Packet record popped from an empty queue.");

    a_drag_has_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] == KIND_DRAG)) |-> (o_m_tdata[23:21] != 3'b000))
        else $error("Drag event sent with no button held.");

    a_move_no_buttons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] == KIND_MOVE)) |-> (o_m_tdata[23:21] == 3'b000))
        else $error("Move event sent with a button held.");

endmodule
